### design/fic_pkg.sv
// Shared constants and helper functions for the Fresnel coefficient pipeline.
// No dependencies; every other file imports this package.
package fic_pkg;

  localparam int WORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MID_BITS      = 62;

  function automatic int fic_min(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int fic_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/fic_req_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on fic_pkg for the default word width.
interface fic_req_if import fic_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] kz_incident_re;
  logic signed [W-1:0] kz_incident_im;
  logic signed [W-1:0] kz_transmitted_re;
  logic signed [W-1:0] kz_transmitted_im;
  logic signed [W-1:0] n_incident_re;
  logic signed [W-1:0] n_incident_im;
  logic signed [W-1:0] n_transmitted_re;
  logic signed [W-1:0] n_transmitted_im;

  modport source (
    output valid, kz_incident_re, kz_incident_im, kz_transmitted_re, kz_transmitted_im,
    output n_incident_re, n_incident_im, n_transmitted_re, n_transmitted_im,
    input  ready
  );
  modport sink (
    input  valid, kz_incident_re, kz_incident_im, kz_transmitted_re, kz_transmitted_im,
    input  n_incident_re, n_incident_im, n_transmitted_re, n_transmitted_im,
    output ready
  );
endinterface

interface fic_rsp_if import fic_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] rs_re;
  logic signed [W-1:0] rs_im;
  logic signed [W-1:0] ts_re;
  logic signed [W-1:0] ts_im;
  logic signed [W-1:0] rp_re;
  logic signed [W-1:0] rp_im;
  logic signed [W-1:0] tp_re;
  logic signed [W-1:0] tp_im;
  logic                s_denominator_zero;
  logic                p_denominator_zero;

  modport source (
    output valid, rs_re, rs_im, ts_re, ts_im, rp_re, rp_im, tp_re, tp_im,
    output s_denominator_zero, p_denominator_zero,
    input  ready
  );
  modport sink (
    input  valid, rs_re, rs_im, ts_re, ts_im, rp_re, rp_im, tp_re, tp_im,
    input  s_denominator_zero, p_denominator_zero,
    output ready
  );
endinterface

### design/fic_cprod.sv
// Two-stage exact complex multiplier, optionally against the conjugate of b.
// The b operand is split in halves; partial products are registered. Uses fic_pkg.
module fic_cprod import fic_pkg::*; #(
  parameter int AW   = WORD_BITS_DEF,
  parameter int BW   = WORD_BITS_DEF,
  parameter bit CONJ = 1'b0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_re_i,
  input  logic signed [AW-1:0] a_im_i,
  input  logic signed [BW-1:0] b_re_i,
  input  logic signed [BW-1:0] b_im_i,
  output logic signed [AW+BW:0] p_re_o,
  output logic signed [AW+BW:0] p_im_o
);
  localparam int L  = BW / 2;
  localparam int HW = BW - L;
  localparam int PW = AW + BW + 1;

  logic signed [L:0]      bre_lo, bim_lo;
  logic signed [HW-1:0]   bre_hi, bim_hi;
  logic signed [AW+L:0]   lo_q [4];
  logic signed [AW+HW-1:0] hi_q [4];
  logic signed [PW-1:0]   full [4];

  assign bre_lo = $signed({1'b0, b_re_i[L-1:0]});
  assign bim_lo = $signed({1'b0, b_im_i[L-1:0]});
  assign bre_hi = $signed(b_re_i[BW-1:L]);
  assign bim_hi = $signed(b_im_i[BW-1:L]);

  // order: ar*br, ai*bi, ar*bi, ai*br
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q[0] <= a_re_i * bre_lo;
      hi_q[0] <= a_re_i * bre_hi;
      lo_q[1] <= a_im_i * bim_lo;
      hi_q[1] <= a_im_i * bim_hi;
      lo_q[2] <= a_re_i * bim_lo;
      hi_q[2] <= a_re_i * bim_hi;
      lo_q[3] <= a_im_i * bre_lo;
      hi_q[3] <= a_im_i * bre_hi;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      full[i] = (PW'(hi_q[i]) <<< L) + PW'(lo_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (CONJ) begin
        p_re_o <= full[0] + full[1];
        p_im_o <= full[3] - full[2];
      end else begin
        p_re_o <= full[0] - full[1];
        p_im_o <= full[2] + full[3];
      end
    end
  end

endmodule

### design/fic_rnd.sv
// Complex round-half-up by an arithmetic shift, then saturate to a narrower word.
// Combinational; the caller registers the result. Uses fic_pkg.
module fic_rnd import fic_pkg::*; #(
  parameter int IW = 2 * WORD_BITS_DEF + 1,
  parameter int SH = FRAC_BITS_DEF,
  parameter int OW = MID_BITS
) (
  input  logic signed [IW-1:0] re_i,
  input  logic signed [IW-1:0] im_i,
  output logic signed [OW-1:0] re_o,
  output logic signed [OW-1:0] im_o
);
  localparam logic signed [IW-1:0] HALF = IW'((2 ** SH) >> 1);
  localparam logic signed [OW-1:0] MAXV = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] MINV = {1'b1, {(OW-1){1'b0}}};

  logic signed [IW-1:0] t [2];
  logic signed [OW-1:0] o [2];

  assign t[0] = (re_i + HALF) >>> SH;
  assign t[1] = (im_i + HALF) >>> SH;
  assign re_o = o[0];
  assign im_o = o[1];

  if (IW - SH > OW) begin : g_sat
    logic [IW-OW:0] hi [2];
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        hi[i] = t[i][IW-1:OW-1];
        if ((&hi[i]) || !(|hi[i])) begin
          o[i] = t[i][OW-1:0];
        end else begin
          o[i] = t[i][IW-1] ? MINV : MAXV;
        end
      end
    end
  end else begin : g_fit
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        o[i] = OW'(t[i]);
      end
    end
  end

endmodule

### design/fic_div.sv
// Pipelined restoring divider: round(x * 2^F / m), ties away from zero,
// saturated to a signed W-bit word. One quotient bit per stage. Uses fic_pkg.
module fic_div import fic_pkg::*; #(
  parameter int XW = 2 * WORD_BITS_DEF + 3,
  parameter int MW = 2 * WORD_BITS_DEF + 2,
  parameter int W  = WORD_BITS_DEF,
  parameter int F  = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic [MW-1:0]        m_i,
  output logic signed [W-1:0]  q_o
);
  localparam int NW = XW + F;
  localparam int CW = fic_max(NW, MW + W + 2);
  localparam int NS = W + 1;

  logic [CW-1:0] r_q    [NS+1];
  logic [MW-1:0] m_q    [NS+1];
  logic [W:0]    qb_q   [NS+1];
  logic [NS:0]   neg_q;
  logic [NS:0]   over_q;

  logic [XW-1:0] ax;
  logic [CW-1:0] r0;
  logic          over0;

  assign ax    = x_i[XW-1] ? XW'(-x_i) : XW'(x_i);
  assign r0    = CW'(ax) << F;
  assign over0 = r0 >= (CW'(m_i) << (W + 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]    <= r0;
      m_q[0]    <= m_i;
      qb_q[0]   <= '0;
      neg_q[0]  <= x_i[XW-1];
      over_q[0] <= over0;
    end
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    localparam int J = NS - k;
    logic [CW-1:0] d;
    logic          ge;
    assign d  = CW'(m_q[k-1]) << J;
    assign ge = r_q[k-1] >= d;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= ge ? r_q[k-1] - d : r_q[k-1];
        qb_q[k]   <= qb_q[k-1] | ((W+1)'(ge) << J);
        m_q[k]    <= m_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        over_q[k] <= over_q[k-1];
      end
    end
  end

  logic          rnd;
  logic [W+1:0]  qr, lim, res, sres;

  always_comb begin
    rnd  = {r_q[NS], 1'b0} >= (CW+1)'(m_q[NS]);
    qr   = (W+2)'(qb_q[NS]) + (W+2)'(rnd);
    lim  = {3'b000, {(W-1){1'b1}}} + (W+2)'(neg_q[NS]);
    res  = (over_q[NS] || (qr > lim)) ? lim : qr;
    sres = neg_q[NS] ? (W+2)'(0) - res : res;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_o <= W'(sres);
    end
  end

endmodule

### design/fresnel_interface_coefficients.sv
// Fresnel interface coefficients: top level of the fixed-point pipeline.
// Depends on fic_pkg, fic_req_if/fic_rsp_if, fic_cprod, fic_rnd and fic_div.
//
// Usage:
//   req_i carries one request per item: complex k1, k2, n1, n2, each part a
//   signed WORD_BITS word with FRAC_BITS fraction bits. rsp_o returns rs, ts,
//   rp, tp (saturated, same format) and the two zero-denominator flags.
//   Complex products, rounding and sums come first, then the dividers,
//   which take one quotient bit per stage and set the depth.
//   Throughput is one request per cycle while the receiver does not stall;
//   every stage holds one item.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_i.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; no pending request survives reset.
//   A zero s (p) denominator raises its flag and drives that pair to zero.
//
module fresnel_interface_coefficients import fic_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fic_req_if.sink    req_i,
  fic_rsp_if.source  rsp_o
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SW   = W + 1;
  localparam int PS   = 2 * W + 3;
  localparam int PA   = 2 * W + 1;
  localparam int C1   = fic_min(PA - F, MID_BITS);
  localparam int PB   = W + C1 + 1;
  localparam int C2   = fic_min(PB - F, MID_BITS);
  localparam int C3   = fic_min(C2 + 1, MID_BITS);
  localparam int PD   = 2 * C3 + 1;
  localparam int LAT  = W + 12;
  localparam int SDLY = 7;

  logic           en;
  logic [LAT-1:0] v_q;

  assign en          = !v_q[LAT-1] || rsp_o.ready;
  assign req_i.ready = en;
  assign rsp_o.valid = v_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], req_i.valid};
    end
  end

  logic signed [W-1:0] k1r, k1i, k2r, k2i;
  assign k1r = req_i.kz_incident_re;
  assign k1i = req_i.kz_incident_im;
  assign k2r = req_i.kz_transmitted_re;
  assign k2i = req_i.kz_transmitted_im;

  // s path operands
  logic signed [SW-1:0] sd_re, sd_im, sr_re, sr_im, st_re, st_im;
  logic                 sz;
  assign sd_re = SW'(k1r) + SW'(k2r);
  assign sd_im = SW'(k1i) + SW'(k2i);
  assign sr_re = SW'(k1r) - SW'(k2r);
  assign sr_im = SW'(k1i) - SW'(k2i);
  assign st_re = $signed({k1r, 1'b0});
  assign st_im = $signed({k1i, 1'b0});
  assign sz    = (sd_re == '0) && (sd_im == '0);

  logic [6*SW-1:0] s_q [SDLY];
  logic [4*W-1:0]  k_q [3];
  logic [LAT-1:0]  sz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0] <= {sd_re, sd_im, sr_re, sr_im, st_re, st_im};
      for (int i = 1; i < SDLY; i++) begin
        s_q[i] <= s_q[i-1];
      end
      k_q[0] <= {k1r, k1i, k2r, k2i};
      for (int i = 1; i < 3; i++) begin
        k_q[i] <= k_q[i-1];
      end
      sz_q <= {sz_q[LAT-2:0], sz};
    end
  end

  // squares and cross product of the indices
  logic signed [PA-1:0] n1sq_re_w, n1sq_im_w, n2sq_re_w, n2sq_im_w, n12_re_w, n12_im_w;
  logic signed [C1-1:0] n1sq_re_r, n1sq_im_r, n2sq_re_r, n2sq_im_r, n12_re_r, n12_im_r;
  logic signed [C1-1:0] n1sq_re_q, n1sq_im_q, n2sq_re_q, n2sq_im_q, n12_re_q, n12_im_q;

  fic_cprod #(.AW(W), .BW(W), .CONJ(1'b0)) u_n1sq (
    .clk_i, .en_i(en),
    .a_re_i(req_i.n_incident_re), .a_im_i(req_i.n_incident_im),
    .b_re_i(req_i.n_incident_re), .b_im_i(req_i.n_incident_im),
    .p_re_o(n1sq_re_w), .p_im_o(n1sq_im_w)
  );
  fic_cprod #(.AW(W), .BW(W), .CONJ(1'b0)) u_n2sq (
    .clk_i, .en_i(en),
    .a_re_i(req_i.n_transmitted_re), .a_im_i(req_i.n_transmitted_im),
    .b_re_i(req_i.n_transmitted_re), .b_im_i(req_i.n_transmitted_im),
    .p_re_o(n2sq_re_w), .p_im_o(n2sq_im_w)
  );
  fic_cprod #(.AW(W), .BW(W), .CONJ(1'b0)) u_n12 (
    .clk_i, .en_i(en),
    .a_re_i(req_i.n_incident_re), .a_im_i(req_i.n_incident_im),
    .b_re_i(req_i.n_transmitted_re), .b_im_i(req_i.n_transmitted_im),
    .p_re_o(n12_re_w), .p_im_o(n12_im_w)
  );

  fic_rnd #(.IW(PA), .SH(F), .OW(C1)) u_rnd_n1sq (
    .re_i(n1sq_re_w), .im_i(n1sq_im_w), .re_o(n1sq_re_r), .im_o(n1sq_im_r)
  );
  fic_rnd #(.IW(PA), .SH(F), .OW(C1)) u_rnd_n2sq (
    .re_i(n2sq_re_w), .im_i(n2sq_im_w), .re_o(n2sq_re_r), .im_o(n2sq_im_r)
  );
  fic_rnd #(.IW(PA), .SH(F), .OW(C1)) u_rnd_n12 (
    .re_i(n12_re_w), .im_i(n12_im_w), .re_o(n12_re_r), .im_o(n12_im_r)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1sq_re_q <= n1sq_re_r;
      n1sq_im_q <= n1sq_im_r;
      n2sq_re_q <= n2sq_re_r;
      n2sq_im_q <= n2sq_im_r;
      n12_re_q  <= n12_re_r;
      n12_im_q  <= n12_im_r;
    end
  end

  // wavevector times index products
  logic signed [W-1:0]  dk1r, dk1i, dk2r, dk2i;
  assign {dk1r, dk1i, dk2r, dk2i} = k_q[2];

  logic signed [PB-1:0] a_re_w, a_im_w, b_re_w, b_im_w, t_re_w, t_im_w;
  logic signed [C2-1:0] a_re_r, a_im_r, b_re_r, b_im_r, t_re_r, t_im_r;
  logic signed [C2-1:0] a_re_q, a_im_q, b_re_q, b_im_q, t_re_q, t_im_q;

  fic_cprod #(.AW(W), .BW(C1), .CONJ(1'b0)) u_a (
    .clk_i, .en_i(en), .a_re_i(dk1r), .a_im_i(dk1i),
    .b_re_i(n2sq_re_q), .b_im_i(n2sq_im_q), .p_re_o(a_re_w), .p_im_o(a_im_w)
  );
  fic_cprod #(.AW(W), .BW(C1), .CONJ(1'b0)) u_b (
    .clk_i, .en_i(en), .a_re_i(dk2r), .a_im_i(dk2i),
    .b_re_i(n1sq_re_q), .b_im_i(n1sq_im_q), .p_re_o(b_re_w), .p_im_o(b_im_w)
  );
  fic_cprod #(.AW(W), .BW(C1), .CONJ(1'b0)) u_t (
    .clk_i, .en_i(en), .a_re_i(dk1r), .a_im_i(dk1i),
    .b_re_i(n12_re_q), .b_im_i(n12_im_q), .p_re_o(t_re_w), .p_im_o(t_im_w)
  );

  fic_rnd #(.IW(PB), .SH(F), .OW(C2)) u_rnd_a (
    .re_i(a_re_w), .im_i(a_im_w), .re_o(a_re_r), .im_o(a_im_r)
  );
  fic_rnd #(.IW(PB), .SH(F), .OW(C2)) u_rnd_b (
    .re_i(b_re_w), .im_i(b_im_w), .re_o(b_re_r), .im_o(b_im_r)
  );
  fic_rnd #(.IW(PB), .SH(F), .OW(C2)) u_rnd_t (
    .re_i(t_re_w), .im_i(t_im_w), .re_o(t_re_r), .im_o(t_im_r)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_re_q <= a_re_r;
      a_im_q <= a_im_r;
      b_re_q <= b_re_r;
      b_im_q <= b_im_r;
      t_re_q <= t_re_r;
      t_im_q <= t_im_r;
    end
  end

  // p numerators and denominator
  logic signed [C2:0]   pd_re_s, pd_im_s, pr_re_s, pr_im_s, pt_re_s, pt_im_s;
  logic signed [C3-1:0] pd_re_r, pd_im_r, pr_re_r, pr_im_r, pt_re_r, pt_im_r;
  logic signed [C3-1:0] pd_re_q, pd_im_q, pr_re_q, pr_im_q, pt_re_q, pt_im_q;

  assign pd_re_s = (C2+1)'(a_re_q) + (C2+1)'(b_re_q);
  assign pd_im_s = (C2+1)'(a_im_q) + (C2+1)'(b_im_q);
  assign pr_re_s = (C2+1)'(a_re_q) - (C2+1)'(b_re_q);
  assign pr_im_s = (C2+1)'(a_im_q) - (C2+1)'(b_im_q);
  assign pt_re_s = $signed({t_re_q, 1'b0});
  assign pt_im_s = $signed({t_im_q, 1'b0});

  fic_rnd #(.IW(C2+1), .SH(0), .OW(C3)) u_sat_pd (
    .re_i(pd_re_s), .im_i(pd_im_s), .re_o(pd_re_r), .im_o(pd_im_r)
  );
  fic_rnd #(.IW(C2+1), .SH(0), .OW(C3)) u_sat_pr (
    .re_i(pr_re_s), .im_i(pr_im_s), .re_o(pr_re_r), .im_o(pr_im_r)
  );
  fic_rnd #(.IW(C2+1), .SH(0), .OW(C3)) u_sat_pt (
    .re_i(pt_re_s), .im_i(pt_im_s), .re_o(pt_re_r), .im_o(pt_im_r)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_re_q <= pd_re_r;
      pd_im_q <= pd_im_r;
      pr_re_q <= pr_re_r;
      pr_im_q <= pr_im_r;
      pt_re_q <= pt_re_r;
      pt_im_q <= pt_im_r;
    end
  end

  logic           pz;
  logic [LAT-8:0] pz_q;
  assign pz = (pd_re_q == '0) && (pd_im_q == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pz_q <= {pz_q[LAT-9:0], pz};
    end
  end

  // quotient fronts: N * conj(D) and |D|^2
  logic signed [SW-1:0] ssd_re, ssd_im, ssr_re, ssr_im, sst_re, sst_im;
  assign {ssd_re, ssd_im, ssr_re, ssr_im, sst_re, sst_im} = s_q[SDLY-1];

  logic signed [PS-1:0] xrs_re, xrs_im, xts_re, xts_im, ms_re;
  logic signed [PD-1:0] xrp_re, xrp_im, xtp_re, xtp_im, mp_re;

  fic_cprod #(.AW(SW), .BW(SW), .CONJ(1'b1)) u_xrs (
    .clk_i, .en_i(en), .a_re_i(ssr_re), .a_im_i(ssr_im),
    .b_re_i(ssd_re), .b_im_i(ssd_im), .p_re_o(xrs_re), .p_im_o(xrs_im)
  );
  fic_cprod #(.AW(SW), .BW(SW), .CONJ(1'b1)) u_xts (
    .clk_i, .en_i(en), .a_re_i(sst_re), .a_im_i(sst_im),
    .b_re_i(ssd_re), .b_im_i(ssd_im), .p_re_o(xts_re), .p_im_o(xts_im)
  );
  fic_cprod #(.AW(SW), .BW(SW), .CONJ(1'b1)) u_ms (
    .clk_i, .en_i(en), .a_re_i(ssd_re), .a_im_i(ssd_im),
    .b_re_i(ssd_re), .b_im_i(ssd_im), .p_re_o(ms_re), .p_im_o()
  );
  fic_cprod #(.AW(C3), .BW(C3), .CONJ(1'b1)) u_xrp (
    .clk_i, .en_i(en), .a_re_i(pr_re_q), .a_im_i(pr_im_q),
    .b_re_i(pd_re_q), .b_im_i(pd_im_q), .p_re_o(xrp_re), .p_im_o(xrp_im)
  );
  fic_cprod #(.AW(C3), .BW(C3), .CONJ(1'b1)) u_xtp (
    .clk_i, .en_i(en), .a_re_i(pt_re_q), .a_im_i(pt_im_q),
    .b_re_i(pd_re_q), .b_im_i(pd_im_q), .p_re_o(xtp_re), .p_im_o(xtp_im)
  );
  fic_cprod #(.AW(C3), .BW(C3), .CONJ(1'b1)) u_mp (
    .clk_i, .en_i(en), .a_re_i(pd_re_q), .a_im_i(pd_im_q),
    .b_re_i(pd_re_q), .b_im_i(pd_im_q), .p_re_o(mp_re), .p_im_o()
  );

  logic [PS-2:0] ms;
  logic [PD-2:0] mp;
  assign ms = ms_re[PS-2:0];
  assign mp = mp_re[PD-2:0];

  logic signed [W-1:0] rs_re_w, rs_im_w, ts_re_w, ts_im_w;
  logic signed [W-1:0] rp_re_w, rp_im_w, tp_re_w, tp_im_w;

  fic_div #(.XW(PS), .MW(PS-1), .W(W), .F(F)) u_div_rs_re (
    .clk_i, .en_i(en), .x_i(xrs_re), .m_i(ms), .q_o(rs_re_w)
  );
  fic_div #(.XW(PS), .MW(PS-1), .W(W), .F(F)) u_div_rs_im (
    .clk_i, .en_i(en), .x_i(xrs_im), .m_i(ms), .q_o(rs_im_w)
  );
  fic_div #(.XW(PS), .MW(PS-1), .W(W), .F(F)) u_div_ts_re (
    .clk_i, .en_i(en), .x_i(xts_re), .m_i(ms), .q_o(ts_re_w)
  );
  fic_div #(.XW(PS), .MW(PS-1), .W(W), .F(F)) u_div_ts_im (
    .clk_i, .en_i(en), .x_i(xts_im), .m_i(ms), .q_o(ts_im_w)
  );
  fic_div #(.XW(PD), .MW(PD-1), .W(W), .F(F)) u_div_rp_re (
    .clk_i, .en_i(en), .x_i(xrp_re), .m_i(mp), .q_o(rp_re_w)
  );
  fic_div #(.XW(PD), .MW(PD-1), .W(W), .F(F)) u_div_rp_im (
    .clk_i, .en_i(en), .x_i(xrp_im), .m_i(mp), .q_o(rp_im_w)
  );
  fic_div #(.XW(PD), .MW(PD-1), .W(W), .F(F)) u_div_tp_re (
    .clk_i, .en_i(en), .x_i(xtp_re), .m_i(mp), .q_o(tp_re_w)
  );
  fic_div #(.XW(PD), .MW(PD-1), .W(W), .F(F)) u_div_tp_im (
    .clk_i, .en_i(en), .x_i(xtp_im), .m_i(mp), .q_o(tp_im_w)
  );

  // drop the pair whose denominator is zero
  assign rsp_o.rs_re = sz_q[LAT-1] ? '0 : rs_re_w;
  assign rsp_o.rs_im = sz_q[LAT-1] ? '0 : rs_im_w;
  assign rsp_o.ts_re = sz_q[LAT-1] ? '0 : ts_re_w;
  assign rsp_o.ts_im = sz_q[LAT-1] ? '0 : ts_im_w;
  assign rsp_o.rp_re = pz_q[LAT-8] ? '0 : rp_re_w;
  assign rsp_o.rp_im = pz_q[LAT-8] ? '0 : rp_im_w;
  assign rsp_o.tp_re = pz_q[LAT-8] ? '0 : tp_re_w;
  assign rsp_o.tp_im = pz_q[LAT-8] ? '0 : tp_im_w;
  assign rsp_o.s_denominator_zero = sz_q[LAT-1];
  assign rsp_o.p_denominator_zero = pz_q[LAT-8];

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v_q[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted while the result is stalled");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v_q) && $stable(sz_q)))
    else $error("pipeline advanced during a stall");

endmodule

### sim/fresnel_interface_coefficients_tb.sv
// Self-checking bench for the Fresnel coefficient pipeline: directed table, then random requests.
// Compares every response with a bit-accurate fixed-point predictor or hand-set values, under random idling.
// Depends on fic_pkg, fic_req_if/fic_rsp_if and fresnel_interface_coefficients.
module fresnel_interface_coefficients_tb;
  import fic_pkg::*;

  localparam int W        = WORD_BITS_DEF;
  localparam int FB       = FRAC_BITS_DEF;
  localparam int N_RAND   = 400;
  localparam int N_DIR    = 13;
  localparam int WATCHDOG = 2000;
  localparam logic [W-1:0] ONE  = 24'h010000;
  localparam logic [W-1:0] TWO  = 24'h020000;
  localparam logic [W-1:0] MAXV = 24'h7fffff;
  localparam logic [W-1:0] MINV = 24'h800000;
  localparam logic [W-1:0] NONE = 24'hff0000;

  typedef logic signed [127:0] wide_t;
  typedef struct { wide_t re, im; } cpx_t;
  typedef struct { logic [W-1:0] f[8]; } fresnel_req_t;
  typedef struct { logic [W-1:0] c[8]; logic sz, pz; } fresnel_coef_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fic_req_if #(.W(W)) req ();
  fic_rsp_if #(.W(W)) rsp ();

  fresnel_interface_coefficients #(.FRAC_BITS(FB), .WORD_BITS(W)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  fresnel_coef_t coef_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_sz = 0;
  int n_pz = 0;
  int idle_cnt = 0;
  bit calm = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic wide_t sat_w(input wide_t v, input int bits);
    wide_t maxv, minv;
    maxv = (wide_t'(1) <<< (bits - 1)) - 1;
    minv = -maxv - 1;
    if (v > maxv) return maxv;
    if (v < minv) return minv;
    return v;
  endfunction

  function automatic wide_t round_mid(input wide_t x);
    return sat_w((x + (wide_t'(1) <<< (FB - 1))) >>> FB, MID_BITS);
  endfunction

  function automatic cpx_t cmul_round(input cpx_t a, input cpx_t b);
    cpx_t r;
    r.re = round_mid(a.re * b.re - a.im * b.im);
    r.im = round_mid(a.re * b.im + a.im * b.re);
    return r;
  endfunction

  function automatic logic [W-1:0] quot_part(input wide_t x, input logic [255:0] m);
    logic [255:0] num, q, r, lim;
    logic neg;
    neg = x < 0;
    num = neg ? 256'(-x) : 256'(x);
    num = num << FB;
    q = num / m;
    r = num % m;
    lim = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
    if (q < (256'd1 << 52) && (r << 1) >= m) q = q + 1;
    if (q > lim) q = lim;
    return neg ? W'(-q) : W'(q);
  endfunction

  function automatic void cdiv(input cpx_t n, input cpx_t d,
                               output logic [W-1:0] re, output logic [W-1:0] im);
    wide_t m, xr, xi;
    m  = d.re * d.re + d.im * d.im;
    xr = n.re * d.re + n.im * d.im;
    xi = n.im * d.re - n.re * d.im;
    if (m == 0) begin
      re = '0;
      im = '0;
    end else begin
      re = quot_part(xr, 256'(m));
      im = quot_part(xi, 256'(m));
    end
  endfunction

  function automatic fresnel_coef_t predict_coef(input fresnel_req_t rq);
    cpx_t k1, k2, n1, n2, sd, sr, st, n1sq, n2sq, a, b, pd, pr, n12, pt;
    fresnel_coef_t o;
    k1.re = wide_t'($signed(rq.f[0])); k1.im = wide_t'($signed(rq.f[1]));
    k2.re = wide_t'($signed(rq.f[2])); k2.im = wide_t'($signed(rq.f[3]));
    n1.re = wide_t'($signed(rq.f[4])); n1.im = wide_t'($signed(rq.f[5]));
    n2.re = wide_t'($signed(rq.f[6])); n2.im = wide_t'($signed(rq.f[7]));
    sd.re = k1.re + k2.re; sd.im = k1.im + k2.im;
    sr.re = k1.re - k2.re; sr.im = k1.im - k2.im;
    st.re = 2 * k1.re;     st.im = 2 * k1.im;
    o.sz = (sd.re == 0) && (sd.im == 0);
    n1sq = cmul_round(n1, n1);
    n2sq = cmul_round(n2, n2);
    a = cmul_round(k1, n2sq);
    b = cmul_round(k2, n1sq);
    pd.re = sat_w(a.re + b.re, MID_BITS); pd.im = sat_w(a.im + b.im, MID_BITS);
    pr.re = sat_w(a.re - b.re, MID_BITS); pr.im = sat_w(a.im - b.im, MID_BITS);
    n12 = cmul_round(n1, n2);
    pt = cmul_round(k1, n12);
    pt.re = sat_w(2 * pt.re, MID_BITS); pt.im = sat_w(2 * pt.im, MID_BITS);
    o.pz = (pd.re == 0) && (pd.im == 0);
    for (int i = 0; i < 8; i++) o.c[i] = '0;
    if (!o.sz) begin
      cdiv(sr, sd, o.c[0], o.c[1]);
      cdiv(st, sd, o.c[2], o.c[3]);
    end
    if (!o.pz) begin
      cdiv(pr, pd, o.c[4], o.c[5]);
      cdiv(pt, pd, o.c[6], o.c[7]);
    end
    return o;
  endfunction

  function automatic logic [W-1:0] rand_part(input int kind);
    case (kind)
      0: return W'($urandom);
      1: return W'($urandom_range(0, 1 << 19) - (1 << 18));
      default: begin
        case ($urandom_range(0, 5))
          0: return MAXV;
          1: return MINV;
          2: return '0;
          3: return ONE;
          4: return NONE;
          default: return W'($urandom_range(0, 3)) - 2;
        endcase
      end
    endcase
  endfunction

  function automatic fresnel_req_t rand_req();
    fresnel_req_t r;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++)
      r.f[i] = rand_part(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
    if ($urandom_range(0, 9) == 0) begin
      r.f[2] = -r.f[0];
      r.f[3] = -r.f[1];
    end
    if ($urandom_range(0, 11) == 0) begin
      for (int i = 4; i < 8; i++) r.f[i] = '0;
    end
    return r;
  endfunction

  task automatic drive_req(input fresnel_req_t rq, input fresnel_coef_t ex);
    req.valid             = 1'b1;
    req.kz_incident_re    = rq.f[0];
    req.kz_incident_im    = rq.f[1];
    req.kz_transmitted_re = rq.f[2];
    req.kz_transmitted_im = rq.f[3];
    req.n_incident_re     = rq.f[4];
    req.n_incident_im     = rq.f[5];
    req.n_transmitted_re  = rq.f[6];
    req.n_transmitted_im  = rq.f[7];
    do @(posedge clk_i); while (!req.ready);
    coef_q.push_back(ex);
    n_sent++;
    @(negedge clk_i);
    req.valid = 1'b0;
    if (!calm && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : rsp_ready_gen
    int hold;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (calm) begin
      rsp.ready <= 1'b1;
    end else if (hold > 0) begin
      hold--;
    end else begin
      rsp.ready <= ~rsp.ready;
      hold = $urandom_range(1, 10) - 1;
    end
  end

  always @(posedge clk_i) begin : rsp_check
    fresnel_coef_t ex;
    bit bad;
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt = 0;
    else if (rst_ni) idle_cnt++;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog: no transfer for %0d cycles, %0d pending", WATCHDOG, coef_q.size());
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && rsp.valid && rsp.ready) begin
      n_recv++;
      if (rsp.s_denominator_zero) n_sz++;
      if (rsp.p_denominator_zero) n_pz++;
      if (coef_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response #%0d", n_recv);
      end else begin
        ex = coef_q.pop_front();
        bad = (rsp.rs_re !== ex.c[0]) || (rsp.rs_im !== ex.c[1]) ||
              (rsp.ts_re !== ex.c[2]) || (rsp.ts_im !== ex.c[3]) ||
              (rsp.rp_re !== ex.c[4]) || (rsp.rp_im !== ex.c[5]) ||
              (rsp.tp_re !== ex.c[6]) || (rsp.tp_im !== ex.c[7]) ||
              (rsp.s_denominator_zero !== ex.sz) || (rsp.p_denominator_zero !== ex.pz);
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch #%0d exp rs %h %h ts %h %h rp %h %h tp %h %h sz %b pz %b",
                     n_recv, ex.c[0], ex.c[1], ex.c[2], ex.c[3], ex.c[4], ex.c[5],
                     ex.c[6], ex.c[7], ex.sz, ex.pz);
            $display("             got rs %h %h ts %h %h rp %h %h tp %h %h sz %b pz %b",
                     rsp.rs_re, rsp.rs_im, rsp.ts_re, rsp.ts_im, rsp.rp_re, rsp.rp_im,
                     rsp.tp_re, rsp.tp_im, rsp.s_denominator_zero, rsp.p_denominator_zero);
          end
        end
      end
    end
  end

  initial begin : stimulus
    fresnel_req_t  dir_in  [N_DIR];
    fresnel_coef_t dir_exp [N_DIR];
    bit            dir_has [N_DIR];
    fresnel_coef_t zero_all;
    zero_all = '{c: '{default: '0}, sz: 1'b1, pz: 1'b1};
    req.valid = 1'b0;
    req.kz_incident_re = '0;    req.kz_incident_im = '0;
    req.kz_transmitted_re = '0; req.kz_transmitted_im = '0;
    req.n_incident_re = '0;     req.n_incident_im = '0;
    req.n_transmitted_re = '0;  req.n_transmitted_im = '0;

    //             k1 re/im    k2 re/im      n1 re/im    n2 re/im
    dir_in[0]  = '{f: '{0, 0, 0, 0, 0, 0, 0, 0}};
    dir_in[1]  = '{f: '{ONE, 0, ONE, 0, ONE, 0, ONE, 0}};
    dir_in[2]  = '{f: '{ONE, 0, 0, 0, ONE, 0, ONE, 0}};
    dir_in[3]  = '{f: '{ONE, 0, NONE, 0, ONE, 0, ONE, 0}};
    dir_in[4]  = '{f: '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}};
    dir_in[5]  = '{f: '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}};
    dir_in[6]  = '{f: '{MAXV, MINV, MINV, MAXV, MAXV, MINV, MINV, MAXV}};
    dir_in[7]  = '{f: '{1, 0, MAXV, 0, ONE, 0, TWO, 0}};
    dir_in[8]  = '{f: '{MAXV, 0, MINV, 0, ONE, 0, ONE, 0}};
    dir_in[9]  = '{f: '{0, ONE, 0, TWO, ONE, 0, TWO, 0}};
    dir_in[10] = '{f: '{ONE, 24'h004000, TWO, 24'h001000, ONE, 24'h000800, 24'h018000, 24'h008000}};
    dir_in[11] = '{f: '{24'h012345, 24'hfedcba, 24'hfedcbb, 24'h012346, ONE, 0, TWO, ONE}};
    dir_in[12] = '{f: '{ONE, ONE, TWO, 0, 0, 0, 0, 0}};
    for (int i = 0; i < N_DIR; i++) dir_has[i] = 1'b0;
    dir_has[0] = 1'b1; dir_exp[0] = zero_all;
    dir_has[1] = 1'b1; dir_exp[1] = '{c: '{0, 0, ONE, 0, 0, 0, ONE, 0}, sz: 0, pz: 0};
    dir_has[2] = 1'b1; dir_exp[2] = '{c: '{ONE, 0, TWO, 0, ONE, 0, TWO, 0}, sz: 0, pz: 0};
    dir_has[3] = 1'b1; dir_exp[3] = zero_all;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++)
      drive_req(dir_in[i], dir_has[i] ? dir_exp[i] : predict_coef(dir_in[i]));

    for (int i = 0; i < N_RAND; i++) begin
      fresnel_req_t rq;
      if (i == N_RAND / 2) begin
        while (coef_q.size() != 0) @(negedge clk_i);
      end
      if (i == N_RAND - 60) calm = 1'b1;
      rq = rand_req();
      drive_req(rq, predict_coef(rq));
    end

    while (coef_q.size() != 0) @(negedge clk_i);
    repeat (W + 30) @(negedge clk_i);
    if (coef_q.size() != 0) errors += coef_q.size();
    $display("sent %0d requests (%0d directed), checked %0d responses", n_sent, N_DIR, n_recv);
    $display("zero s denominators: %0d, zero p denominators: %0d, mismatches: %0d",
             n_sz, n_pz, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
